FILE: rtl/core/rect_mask_dilation_macros.svh
// Assertion helpers for the mask dilation block.
// Compiled out when SYNTHESIS is set.
`ifndef RECT_MASK_DILATION_MACROS_SVH
`define RECT_MASK_DILATION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RMD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RMD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define RMD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/core/rmd_pkg.sv
package rmd_pkg;

  // mask store geometry
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;

  localparam int RowAw = $clog2(MaxHeight);
  localparam int ColAw = $clog2(MaxWidth);
  // wide enough for sizes, index + radius and the sum of both axes
  localparam int CmpW  = $clog2(MaxWidth + MaxHeight + 512);

  localparam int SizeRegW   = 9;
  localparam int RadiusRegW = 8;
  localparam int IndexW     = 8;
  localparam int ApbAw      = 4;
  localparam int ApbDw      = 32;

  localparam logic [SizeRegW-1:0]   WidthRst  = 9'd256;
  localparam logic [SizeRegW-1:0]   HeightRst = 9'd256;
  localparam logic [RadiusRegW-1:0] TRadRst   = 8'd1;
  localparam logic [RadiusRegW-1:0] FRadRst   = 8'd1;

  typedef enum logic [1:0] {
    REG_MASK_WIDTH  = 2'd0,
    REG_MASK_HEIGHT = 2'd1,
    REG_TIME_RADIUS = 2'd2,
    REG_FREQ_RADIUS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [SizeRegW-1:0]   mask_width;
    logic [SizeRegW-1:0]   mask_height;
    logic [RadiusRegW-1:0] time_radius;
    logic [RadiusRegW-1:0] freq_radius;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [RowAw-1:0]    addr;
    logic [MaxWidth-1:0] wdata;
  } ram_req_t;

endpackage

FILE: rtl/core/rmd_cfg_regs.sv
module rmd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rmd_pkg::ApbAw-1:0]    paddr,
  input  logic [rmd_pkg::ApbDw-1:0]    pwdata,
  output logic [rmd_pkg::ApbDw-1:0]    prdata,
  output logic                         pready,
  output rmd_pkg::cfg_t                cfg_o
);
  import rmd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MASK_WIDTH:  cfg_d.mask_width  = pwdata[SizeRegW-1:0];
        REG_MASK_HEIGHT: cfg_d.mask_height = pwdata[SizeRegW-1:0];
        REG_TIME_RADIUS: cfg_d.time_radius = pwdata[RadiusRegW-1:0];
        REG_FREQ_RADIUS: cfg_d.freq_radius = pwdata[RadiusRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MASK_WIDTH:  prdata = ApbDw'(cfg_q.mask_width);
      REG_MASK_HEIGHT: prdata = ApbDw'(cfg_q.mask_height);
      REG_TIME_RADIUS: prdata = ApbDw'(cfg_q.time_radius);
      REG_FREQ_RADIUS: prdata = ApbDw'(cfg_q.freq_radius);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_width  <= WidthRst;
      cfg_q.mask_height <= HeightRst;
      cfg_q.time_radius <= TRadRst;
      cfg_q.freq_radius <= FRadRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rmd_row_ram.sv
module rmd_row_ram #(
  parameter int Depth = 256,
  parameter int Width = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rmd_seq.sv
module rmd_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rmd_pkg::cfg_t                    cfg_i,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd_i,
  input  logic [rmd_pkg::IndexW-1:0]       time_index_i,
  input  logic [rmd_pkg::IndexW-1:0]       freq_index_i,
  input  logic                             flag_bit_i,
  output rmd_pkg::ram_req_t                ram_req_o,
  input  logic [rmd_pkg::MaxWidth-1:0]     ram_rdata_i,
  output logic                             valid_o,
  output logic                             dilated_flag_o,
  output logic                             out_of_range_o
);
  import rmd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_WR_WB = 5'b00100,
    ST_MASK  = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // item beat
  logic              cmd_q, bit_q;
  logic [IndexW-1:0] x_q, y_q;

  // window bounds and scan state
  logic [CmpW-1:0]     left_q, left_d, right_q, right_d;
  logic [CmpW-1:0]     row_q, row_d, bottom_q, bottom_d;
  logic [MaxWidth-1:0] colmask_q, colmask_d, col_c;
  logic                hit_q, hit_d, hit_now;
  logic                flag_q, flag_d, oor_q, oor_d;

  // bound arithmetic
  logic [CmpW-1:0] x_ext, y_ext, tr_ext, fr_ext, wreg_ext, hreg_ext;
  logic [CmpW-1:0] w_c, h_c, x_hi, y_hi;
  logic            in_range;
  logic [MaxWidth-1:0] row_wr;

  assign x_ext    = CmpW'(x_q);
  assign y_ext    = CmpW'(y_q);
  assign tr_ext   = CmpW'(cfg_i.time_radius);
  assign fr_ext   = CmpW'(cfg_i.freq_radius);
  assign wreg_ext = CmpW'(cfg_i.mask_width);
  assign hreg_ext = CmpW'(cfg_i.mask_height);

  always_comb begin
    if (wreg_ext == '0) begin
      w_c = CmpW'(1);
    end else if (wreg_ext > CmpW'(MaxWidth)) begin
      w_c = CmpW'(MaxWidth);
    end else begin
      w_c = wreg_ext;
    end
    if (hreg_ext == '0) begin
      h_c = CmpW'(1);
    end else if (hreg_ext > CmpW'(MaxHeight)) begin
      h_c = CmpW'(MaxHeight);
    end else begin
      h_c = hreg_ext;
    end
  end

  assign in_range = (x_ext < w_c) && (y_ext < h_c);
  assign x_hi     = x_ext + tr_ext;
  assign y_hi     = y_ext + fr_ext;

  // column window as a bit mask over the row word
  always_comb begin
    for (int c = 0; c < MaxWidth; c++) begin
      col_c[c] = (CmpW'(c) >= left_q) && (CmpW'(c) <= right_q);
    end
  end

  // row with the one bit replaced
  always_comb begin
    row_wr = ram_rdata_i;
    row_wr[x_ext[ColAw-1:0]] = bit_q;
  end

  assign hit_now = hit_q | (|(ram_rdata_i & colmask_q));

  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    left_d    = left_q;
    right_d   = right_q;
    row_d     = row_q;
    bottom_d  = bottom_q;
    colmask_d = colmask_q;
    hit_d     = hit_q;
    flag_d    = flag_q;
    oor_d     = oor_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.re    = 1'b0;
    ram_req_o.addr  = row_q[RowAw-1:0];
    ram_req_o.wdata = row_wr;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!in_range) begin
          if (cmd_q == CMD_READ) begin
            valid_d = 1'b1;
            flag_d  = 1'b0;
            oor_d   = 1'b1;
          end
          state_d = ST_IDLE;
        end else if (cmd_q == CMD_WRITE) begin
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = y_ext[RowAw-1:0];
          state_d        = ST_WR_WB;
        end else begin
          left_d   = (x_ext > tr_ext) ? x_ext - tr_ext : '0;
          right_d  = (x_hi < w_c - CmpW'(1)) ? x_hi : w_c - CmpW'(1);
          row_d    = (y_ext > fr_ext) ? y_ext - fr_ext : '0;
          bottom_d = (y_hi < h_c - CmpW'(1)) ? y_hi : h_c - CmpW'(1);
          state_d  = ST_MASK;
        end
      end
      ST_WR_WB: begin
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = y_ext[RowAw-1:0];
        state_d        = ST_IDLE;
      end
      ST_MASK: begin
        colmask_d    = col_c;
        hit_d        = 1'b0;
        ram_req_o.re = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (row_q == bottom_q) begin
          valid_d = 1'b1;
          flag_d  = hit_now;
          oor_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          row_d          = row_q + CmpW'(1);
          hit_d          = hit_now;
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = row_d[RowAw-1:0];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && (state_q == ST_IDLE)) begin
      cmd_q <= cmd_i;
      x_q   <= time_index_i;
      y_q   <= freq_index_i;
      bit_q <= flag_bit_i;
    end
    left_q    <= left_d;
    right_q   <= right_d;
    row_q     <= row_d;
    bottom_q  <= bottom_d;
    colmask_q <= colmask_d;
    hit_q     <= hit_d;
    flag_q    <= flag_d;
    oor_q     <= oor_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign valid_o        = valid_q;
  assign dilated_flag_o = flag_q;
  assign out_of_range_o = oor_q;

endmodule

FILE: rtl/core/rect_mask_dilation.sv
// Channel  | Handshake                          | Beat
// ---------+------------------------------------+------------------------------------------
// command  | start / busy                       | cmd_i, time_index_i, freq_index_i,
//          |                                    | flag_bit_i
// result   | valid_o (one-cycle strobe)         | dilated_flag_o, out_of_range_o
// config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A command beat is taken when start is high and busy low. Writes are a
// read-modify-write of one row word and give no result. Reads scan one
// row word per cycle through the single-port row RAM over the clipped
// window (1 .. 2*freq_radius+1 rows) and then strobe the result. For a
// position out of range the command ends in ST_PREP; a read then gives a
// result with out_of_range_o set. Reset clears the FSM and loads the config
// registers with their defaults; the mask RAM holds garbage until written.
// The result side cannot stall; each result is one cycle.
`include "rect_mask_dilation_macros.svh"

module rect_mask_dilation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [rmd_pkg::IndexW-1:0]    time_index_i,
  input  logic [rmd_pkg::IndexW-1:0]    freq_index_i,
  input  logic                          flag_bit_i,
  // result channel
  output logic                          valid_o,
  output logic                          dilated_flag_o,
  output logic                          out_of_range_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmd_pkg::ApbAw-1:0]     paddr,
  input  logic [rmd_pkg::ApbDw-1:0]     pwdata,
  output logic [rmd_pkg::ApbDw-1:0]     prdata,
  output logic                          pready
);
  import rmd_pkg::*;

  cfg_t                cfg;
  ram_req_t            ram_req;
  logic [MaxWidth-1:0] ram_rdata;

  // size and radius registers
  rmd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one row word per frequency row, one bit per time column
  rmd_row_ram #(
    .Depth (MaxHeight),
    .Width (MaxWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // bounds, RMW for writes, row scan for reads
  rmd_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .time_index_i   (time_index_i),
    .freq_index_i   (freq_index_i),
    .flag_bit_i     (flag_bit_i),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .valid_o        (valid_o),
    .dilated_flag_o (dilated_flag_o),
    .out_of_range_o (out_of_range_o)
  );

  // an accepted beat always occupies the sequencer next cycle
  `RMD_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "beat taken but not busy")
  // out-of-range results never report a hit
  `RMD_ASSERT_IMP(a_oor_no_hit, clk_i, rst_ni, valid_o, !(dilated_flag_o && out_of_range_o), "hit with out_of_range")
  // at most one result per item, never two in a row
  `RMD_ASSERT_NXT(a_single_pulse, clk_i, rst_ni, valid_o, !valid_o, "back-to-back result strobes")
  // RAM port does one access per cycle
  `RMD_ASSERT_IMP(a_ram_one_op, clk_i, rst_ni, ram_req.we, !ram_req.re, "RAM read and write together")

endmodule
